/* hw/rtl/nms_pkg.sv */
package nms_pkg;

	// Width of the matrix size register and of the row and column result fields.
	localparam int unsigned SIZE_WIDTH = 9;
	localparam int unsigned POS_WIDTH = 8;
	localparam int unsigned TOTAL_WIDTH = 32;

	// Number of neighbours that exist around one element: corner, edge or interior.
	typedef enum logic [1:0] {
		CNT_THREE,
		CNT_FIVE,
		CNT_EIGHT
	} nbr_cnt_t;

	// Side information that travels with one result through the divider.
	typedef struct packed {
		logic [POS_WIDTH-1:0] row;
		logic [POS_WIDTH-1:0] col;
		logic                 last;
		logic                 below_diag;
	} res_tag_t;

endpackage

/* hw/rtl/nms_ram.sv */
module nms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AddrWidth-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [AddrWidth-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

/* hw/rtl/nms_mean_div.sv */
module nms_mean_div import nms_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_WIDTH+2:0] sum,
	input  nbr_cnt_t                      cnt,
	input  res_tag_t                      in_tag,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] mean,
	output res_tag_t                      out_tag
);

	localparam int SumWidth = SAMPLE_WIDTH + 3;
	localparam int ProdWidth = 2 * SumWidth;

	// Reciprocals scaled by two to the power of the magnitude width.
	localparam logic [63:0] RecThreeFull = (64'd1 << SumWidth) / 64'd3;
	localparam logic [63:0] RecFiveFull = (64'd1 << SumWidth) / 64'd5;
	localparam logic [63:0] RecEightFull = (64'd1 << SumWidth) / 64'd8;
	localparam logic [SumWidth-1:0] RecThree = RecThreeFull[SumWidth-1:0];
	localparam logic [SumWidth-1:0] RecFive = RecFiveFull[SumWidth-1:0];
	localparam logic [SumWidth-1:0] RecEight = RecEightFull[SumWidth-1:0];
	localparam logic [SumWidth-1:0] DivThree = SumWidth'(3);
	localparam logic [SumWidth-1:0] DivFive = SumWidth'(5);
	localparam logic [SumWidth-1:0] DivEight = SumWidth'(8);

	logic                       valid_s1;
	logic signed [SumWidth-1:0] sum_s1;
	nbr_cnt_t                   cnt_s1;
	res_tag_t                   tag_s1;

	logic                valid_s2;
	logic [SumWidth-1:0] quot_s2;
	logic [SumWidth-1:0] mag_s2;
	logic                neg_s2;
	nbr_cnt_t            cnt_s2;
	res_tag_t            tag_s2;

	logic                 adv_s1;
	logic                 adv_s2;
	logic [SumWidth-1:0]  mag;
	logic [SumWidth-1:0]  rec;
	logic [ProdWidth-1:0] prod;
	logic [SumWidth-1:0]  back;
	logic [SumWidth-1:0]  divisor;
	logic [SumWidth-1:0]  rem;
	logic [SumWidth-1:0]  quot;

	// Each stage moves on when the stage after it is empty or moving.
	assign adv_s2 = !valid_s2 || !out_stall;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// First stage: magnitude of the sum and multiplication by the reciprocal.
	always_comb begin
		mag = sum_s1[SumWidth-1] ? SumWidth'(-sum_s1) : SumWidth'(sum_s1);
		case (cnt_s1)
			CNT_THREE: rec = RecThree;
			CNT_FIVE:  rec = RecFive;
			CNT_EIGHT: rec = RecEight;
			default:   rec = RecEight;
		endcase
		prod = ProdWidth'(mag) * ProdWidth'(rec);
	end

	// Second stage: the estimate is at most one low, so one compare corrects it.
	always_comb begin
		case (cnt_s2)
			CNT_THREE: begin
				back = quot_s2 + (quot_s2 << 1);
				divisor = DivThree;
			end
			CNT_FIVE: begin
				back = quot_s2 + (quot_s2 << 2);
				divisor = DivFive;
			end
			CNT_EIGHT: begin
				back = quot_s2 << 3;
				divisor = DivEight;
			end
			default: begin
				back = quot_s2 << 3;
				divisor = DivEight;
			end
		endcase
		rem = mag_s2 - back;
		quot = (rem >= divisor) ? quot_s2 + SumWidth'(1) : quot_s2;
	end

	// The sign goes back on after the division, which truncates toward zero.
	assign mean = neg_s2 ? SAMPLE_WIDTH'(-quot) : SAMPLE_WIDTH'(quot);
	assign out_tag = tag_s2;
	assign out_valid = valid_s2;

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			sum_s1 <= sum;
			cnt_s1 <= cnt;
			tag_s1 <= in_tag;
		end
		if (adv_s2 && valid_s1) begin
			quot_s2 <= prod[ProdWidth-1:SumWidth];
			mag_s2 <= mag;
			neg_s2 <= sum_s1[SumWidth-1];
			cnt_s2 <= cnt_s1;
			tag_s2 <= tag_s1;
		end
	end

endmodule

/* hw/rtl/neighbour_mean_smoother.sv */
// An item passes the memory read stage, the window stage, the divider stages and the output register.
// Throughput: one item per cycle while the divider and output do not stall; results leave at
// one per cycle, so an item with two or four results holds the input until its last result
// enters the divider (the single neighbour-sum adder serves one result a cycle).
// Reset clears the pipeline, the position, the running sum and sets the size to 8, or to MAX_SIZE if smaller;
// the row memory is not cleared. A size write also restarts the matrix.
module neighbour_mean_smoother import nms_pkg::*; #(
	parameter int MAX_SIZE = 256,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [SIZE_WIDTH-1:0]          cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] smoothed,
	output logic [POS_WIDTH-1:0]           out_row,
	output logic [POS_WIDTH-1:0]           out_col,
	output logic                           last,
	output logic signed [TOTAL_WIDTH-1:0]  total
);

	localparam int PosWidth = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int SumWidth = SAMPLE_WIDTH + 3;
	localparam int ResetLast = ((MAX_SIZE < 8) ? MAX_SIZE : 8) - 1;

	// Which rows and columns of results an item produces, and edge conditions.
	typedef struct packed {
		logic row0_ok;
		logic row1_ok;
		logic col0_ok;
		logic col1_ok;
		logic row_ge2;
		logic col_ge2;
		logic final_elem;
	} win_flags_t;

	logic [PosWidth-1:0] row_q;
	logic [PosWidth-1:0] col_q;
	logic [PosWidth-1:0] last_q;
	logic [31:0]         cfg_size;
	logic [PosWidth-1:0] cfg_last;
	logic                accept;
	win_flags_t          flags_in;

	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic [PosWidth-1:0]            row_s1;
	logic [PosWidth-1:0]            col_s1;
	win_flags_t                     flags_s1;

	logic [2*SAMPLE_WIDTH-1:0]      rd_data;
	logic signed [SAMPLE_WIDTH-1:0] up_data;
	logic signed [SAMPLE_WIDTH-1:0] mid_data;

	logic signed [SAMPLE_WIDTH-1:0] win_q [3][3];
	logic                valid_s2;
	logic                ro_s2;
	logic                co_s2;
	logic [PosWidth-1:0] row_s2;
	logic [PosWidth-1:0] col_s2;
	win_flags_t          flags_s2;

	logic                       s1_go;
	logic                       s1_free;
	logic                       s2_emit;
	logic                       s2_more_col;
	logic                       s2_more_row;
	logic                       s2_final;
	logic                       s2_free;
	logic                       has_result;
	logic [2:0]                 row_use;
	logic [2:0]                 col_use;
	logic signed [SumWidth-1:0] nbr_sum;
	nbr_cnt_t                   nbr_cnt;
	logic [PosWidth-1:0]        res_row;
	logic [PosWidth-1:0]        res_col;
	res_tag_t                   res_tag;

	logic                           div_stall;
	logic                           div_valid;
	logic signed [SAMPLE_WIDTH-1:0] div_mean;
	res_tag_t                       div_tag;

	logic                           out_free;
	logic                           take;
	logic signed [TOTAL_WIDTH-1:0]  mean_ext;
	logic signed [TOTAL_WIDTH-1:0]  sum_next;
	logic signed [TOTAL_WIDTH-1:0]  sum_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] smoothed_q;
	logic [POS_WIDTH-1:0]           out_row_q;
	logic [POS_WIDTH-1:0]           out_col_q;
	logic                           last_res_q;
	logic signed [TOTAL_WIDTH-1:0]  total_q;

	// Matrix size written by the host, held between two and the memory depth.
	always_comb begin
		cfg_size = 32'(cfg_wdata);
		if (cfg_size < 32'd2) begin
			cfg_size = 32'd2;
		end else if (cfg_size > 32'(MAX_SIZE)) begin
			cfg_size = 32'(MAX_SIZE);
		end
	end
	assign cfg_last = PosWidth'(cfg_size - 32'd1);

	// Handshake chain from the output register back to the input.
	assign out_free = !out_valid_q || !out_stall;
	assign take = div_valid && out_free;
	assign s2_emit = valid_s2 && !div_stall;
	assign s2_more_col = !co_s2 && flags_s2.col1_ok;
	assign s2_more_row = !ro_s2 && flags_s2.row1_ok;
	assign s2_final = !s2_more_col && !s2_more_row;
	assign s2_free = !valid_s2 || (s2_emit && s2_final);
	assign s1_go = valid_s1 && s2_free;
	assign s1_free = !valid_s1 || s1_go;
	assign in_stall = !s1_free;
	assign accept = in_valid && !in_stall;

	// Position of the incoming item and what it will produce.
	always_comb begin
		flags_in.row0_ok = (row_q != '0);
		flags_in.row1_ok = (row_q == last_q);
		flags_in.col0_ok = (col_q != '0);
		flags_in.col1_ok = (col_q == last_q);
		flags_in.row_ge2 = (row_q > PosWidth'(1));
		flags_in.col_ge2 = (col_q > PosWidth'(1));
		flags_in.final_elem = (row_q == last_q) && (col_q == last_q);
	end

	// Row and column counters; a size write restarts the matrix.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			last_q <= PosWidth'(ResetLast);
		end else if (cfg_we) begin
			row_q <= '0;
			col_q <= '0;
			last_q <= cfg_last;
		end else if (accept) begin
			if (col_q == last_q) begin
				col_q <= '0;
				row_q <= (row_q == last_q) ? '0 : row_q + PosWidth'(1);
			end else begin
				col_q <= col_q + PosWidth'(1);
			end
		end
	end

	// Row memory: each entry holds the two rows above the current one at that column.
	nms_ram #(
		.WIDTH(2 * SAMPLE_WIDTH),
		.DEPTH(MAX_SIZE)
	) u_row_ram (
		.clk  (clk),
		.we   (s1_go),
		.waddr(col_s1),
		.wdata({mid_data, sample_s1}),
		.re   (accept),
		.raddr(col_q),
		.rdata(rd_data)
	);

	assign up_data = rd_data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
	assign mid_data = rd_data[SAMPLE_WIDTH-1:0];

	// First stage waits for the memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			row_s1 <= row_q;
			col_s1 <= col_q;
			flags_s1 <= flags_in;
		end
	end

	// The window shifts one column for every item, whether it produces results or not.
	assign has_result = (flags_s1.row0_ok || flags_s1.row1_ok) &&
		(flags_s1.col0_ok || flags_s1.col1_ok);

	always_ff @(posedge clk) begin
		if (s1_go) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= up_data;
			win_q[1][2] <= mid_data;
			win_q[2][2] <= sample_s1;
			row_s2 <= row_s1;
			col_s2 <= col_s1;
			flags_s2 <= flags_s1;
		end
	end

	// Result sequencer: walks the row above, then the last row, column by column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			ro_s2 <= 1'b0;
			co_s2 <= 1'b0;
		end else if (s1_go) begin
			valid_s2 <= has_result;
			ro_s2 <= !flags_s1.row0_ok;
			co_s2 <= !flags_s1.col0_ok;
		end else if (s2_emit) begin
			if (s2_more_col) begin
				co_s2 <= 1'b1;
			end else if (s2_more_row) begin
				ro_s2 <= 1'b1;
				co_s2 <= !flags_s2.col0_ok;
			end else begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Rows and columns of the window that hold existing neighbours of this result.
	always_comb begin
		if (ro_s2) begin
			row_use = 3'b110;
		end else begin
			row_use = {2'b11, flags_s2.row_ge2};
		end
		if (co_s2) begin
			col_use = 3'b110;
		end else begin
			col_use = {2'b11, flags_s2.col_ge2};
		end
		if ((&row_use) && (&col_use)) begin
			nbr_cnt = CNT_EIGHT;
		end else if ((&row_use) || (&col_use)) begin
			nbr_cnt = CNT_FIVE;
		end else begin
			nbr_cnt = CNT_THREE;
		end
	end

	// Sum of the existing neighbours, leaving out the centre.
	always_comb begin
		int ck;
		int cm;
		ck = ro_s2 ? 2 : 1;
		cm = co_s2 ? 2 : 1;
		nbr_sum = '0;
		for (int k = 0; k < 3; k++) begin
			for (int m = 0; m < 3; m++) begin
				if (row_use[k] && col_use[m] && !(k == ck && m == cm)) begin
					nbr_sum = nbr_sum + SumWidth'(win_q[k][m]);
				end
			end
		end
	end

	// Position of the result and whether it counts toward the running sum.
	always_comb begin
		res_row = ro_s2 ? row_s2 : row_s2 - PosWidth'(1);
		res_col = co_s2 ? col_s2 : col_s2 - PosWidth'(1);
		res_tag.row = POS_WIDTH'(res_row);
		res_tag.col = POS_WIDTH'(res_col);
		res_tag.last = flags_s2.final_elem && ro_s2 && co_s2;
		res_tag.below_diag = ({1'b0, res_col} + (PosWidth + 1)'(2)) <= {1'b0, res_row};
	end

	nms_mean_div #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_mean_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s2),
		.in_stall (div_stall),
		.sum      (nbr_sum),
		.cnt      (nbr_cnt),
		.in_tag   (res_tag),
		.out_valid(div_valid),
		.out_stall(!out_free),
		.mean     (div_mean),
		.out_tag  (div_tag)
	);

	// Running sum below the second diagonal, in result order.
	assign mean_ext = TOTAL_WIDTH'(div_mean);
	assign sum_next = sum_q + mean_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				sum_q <= '0;
			end else if (take) begin
				if (div_tag.last) begin
					sum_q <= '0;
				end else if (div_tag.below_diag) begin
					sum_q <= sum_next;
				end
			end
			if (out_free) begin
				out_valid_q <= div_valid;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (take) begin
			smoothed_q <= div_mean;
			out_row_q <= div_tag.row;
			out_col_q <= div_tag.col;
			last_res_q <= div_tag.last;
			if (div_tag.last) begin
				total_q <= div_tag.below_diag ? sum_next : sum_q;
			end else begin
				total_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign smoothed = smoothed_q;
	assign out_row = out_row_q;
	assign out_col = out_col_q;
	assign last = last_res_q;
	assign total = total_q;

endmodule
